// File: hw/rtl/pba_pkg.sv
// Shared types, codes and defaults of the page block allocator.
package pba_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam logic [4:0] PAGE_SIZE_LOG2_RESET = 5'd10;
   localparam logic [8:0] POOL_PAGES_RESET = 9'd256;

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_REALLOC = 2'd1;
   localparam logic [1:0] MODE_FREE    = 2'd2;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOPAGES  = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_LISTFULL = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   localparam logic CSR_PAGE_SIZE_LOG2 = 1'b0;
   localparam logic CSR_POOL_PAGES     = 1'b1;

   typedef struct packed {
      logic [7:0] start;
      logic [8:0] len;
   } fl_entry_type;

   typedef enum logic [3:0] {
      S_IDLE, S_NEED, S_BREAD, S_BWAIT, S_SREAD, S_SCMP, S_ERASE_RD, S_ERASE_WR,
      S_BUMP, S_FIN, S_APPEND, S_RESP
   } state_type;

endpackage

// File: hw/rtl/pba_ram.sv
// Generic simple dual-port RAM with registered read.
module pba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/pba_need.sv
// Byte size to page count rounding, registered at request accept.
module pba_need (
   input  logic        clock,
   input  logic        load,
   input  logic [23:0] size_bytes,
   input  logic [4:0]  page_size_log2,
   output logic [24:0] need_ff
);

   logic [24:0] need_in;
   logic [23:0] mask;

   always_comb begin
      mask = ~(24'hFF_FFFF << page_size_log2);
      if (page_size_log2 >= 5'd24) begin
         need_in = {24'd0, size_bytes != 24'd0};
      end else begin
         need_in = {1'b0, size_bytes >> page_size_log2}
                 + {24'd0, (size_bytes & mask) != 24'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         need_ff <= need_in;
      end
   end

endmodule

// File: hw/rtl/page_block_allocator.sv
// Page block allocator top level: request sequencer over free-list and block-length RAMs.
//   channel | direction | handshake            | words
//   req     | in        | req_valid/req_stall  | mode, size, block page, block given
//   rsp     | out       | rsp_valid/rsp_stall  | status, grant, copy, open count
//   csr     | in        | csr_we               | page_size_log2, pool_pages
// One request at a time. Allocate takes the first free-list entry that fits, shifting later
// entries one place down over it, else pages from the bump pointer; a fitting realloc keeps
// its block, a moving realloc allocates and then appends the old block to the free list, and
// free appends its block. A new request can be taken in the cycle after the result word leaves.
// Reset is synchronous and clears counters, bump pointer and block valid bits at once.
// req_stall stays high while a request is in work or a result word waits to be taken.
module page_block_allocator
   import pba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [23:0]        req_size_bytes,
   input  logic [7:0]         req_block_page,
   input  logic               req_block_given,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_start_page,
   output logic [8:0]         rsp_granted_pages,
   output logic               rsp_copy_needed,
   output logic [7:0]         rsp_copy_from_page,
   output logic [8:0]         rsp_copy_pages,
   output logic signed [15:0] rsp_open_blocks,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [8:0]         csr_wdata
);

   localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = PW + 1;
   localparam logic [CW-1:0] MAXC = CW'(TABLE_DEPTH);

   state_type state_ff, state_in;

   logic [4:0]    psl_ff;
   logic [8:0]    pool_ff;
   logic [1:0]    mode_ff, mode_in;
   logic [7:0]    page_ff, page_in;
   logic          given_ff, given_in;
   logic [24:0]   need_ff;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic          found_ff, found_in;
   logic [7:0]    fstart_ff, fstart_in;
   logic [8:0]    flen_ff, flen_in;
   logic [8:0]    old_ff, old_in;
   logic [CW-1:0] free_count_ff, free_count_in;
   logic [CW-1:0] bump_ff, bump_in;
   logic [CW-1:0] block_count_ff, block_count_in;
   logic [15:0]   outstanding_ff, outstanding_in;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic          set_valid;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    r_status_ff, r_status_in;
   logic [7:0]    r_start_ff, r_start_in;
   logic [8:0]    r_len_ff, r_len_in;
   logic          r_cp_ff, r_cp_in;
   logic [7:0]    r_cfrom_ff, r_cfrom_in;
   logic [8:0]    r_clen_ff, r_clen_in;

   logic          accept;
   logic          is_alloc, is_realloc, is_free;
   logic [PW-1:0] pidx, bidx;
   logic [CW-1:0] j_dec;
   logic [2:0]    lk_status;
   logic          list_full;
   logic [25:0]   bump_sum;
   logic [25:0]   limit;
   logic          bump_fits;

   logic          fl_we;
   logic [PW-1:0] fl_waddr, fl_raddr;
   fl_entry_type  fl_wdata, fl_rdata;
   logic          blk_we;
   logic [PW-1:0] blk_waddr;
   logic [8:0]    blk_wdata, blk_rdata;

   pba_need u_need (
      .clock          (clock),
      .load           (accept),
      .size_bytes     (req_size_bytes),
      .page_size_log2 (psl_ff),
      .need_ff        (need_ff)
   );

   pba_ram #(.WIDTH($bits(fl_entry_type)), .DEPTH(TABLE_DEPTH)) u_free_ram (
      .clock (clock),
      .we    (fl_we),
      .waddr (fl_waddr),
      .wdata (fl_wdata),
      .raddr (fl_raddr),
      .rdata (fl_rdata)
   );

   pba_ram #(.WIDTH(9), .DEPTH(TABLE_DEPTH)) u_block_ram (
      .clock (clock),
      .we    (blk_we),
      .waddr (blk_waddr),
      .wdata (blk_wdata),
      .raddr (pidx),
      .rdata (blk_rdata)
   );

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept = req_valid && !req_stall;

   assign is_realloc = (mode_ff == MODE_REALLOC) && given_ff;
   assign is_free    = (mode_ff == MODE_FREE);
   assign is_alloc   = (mode_ff == MODE_ALLOC) || ((mode_ff == MODE_REALLOC) && !given_ff);

   assign pidx = PW'(page_ff);
   assign bidx = bump_ff[PW-1:0];
   assign j_dec = j_ff - 1'b1;
   assign list_full = free_count_ff >= MAXC;
   assign bump_sum = 26'(bump_ff) + 26'(need_ff);
   assign limit = (32'(pool_ff) < TABLE_DEPTH) ? 26'(pool_ff) : 26'(TABLE_DEPTH);
   assign bump_fits = (32'(bump_ff) < TABLE_DEPTH) && (bump_sum <= limit);

   always_comb begin
      if (block_count_ff == '0) begin
         lk_status = ST_EMPTY;
      end else if (!(32'(page_ff) < TABLE_DEPTH) || !valid_ff[pidx]) begin
         lk_status = ST_NOTFOUND;
      end else begin
         lk_status = ST_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_NEED;
         end
         S_NEED: begin
            if (is_alloc) begin
               state_in = (free_count_ff == '0) ? S_BUMP : S_SREAD;
            end else if (is_realloc) begin
               state_in = (lk_status != ST_OK) ? S_RESP : S_BREAD;
            end else if (is_free) begin
               state_in = (lk_status != ST_OK || list_full) ? S_RESP : S_BREAD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_BREAD: state_in = S_BWAIT;
         S_BWAIT: begin
            if (is_free) begin
               state_in = S_APPEND;
            end else if (25'(blk_rdata) >= need_ff) begin
               state_in = S_RESP;
            end else begin
               state_in = (free_count_ff == '0) ? S_BUMP : S_SREAD;
            end
         end
         S_SREAD: state_in = S_SCMP;
         S_SCMP: begin
            if (25'(fl_rdata.len) >= need_ff) begin
               state_in = (i_ff + 1'b1 < free_count_ff) ? S_ERASE_RD : S_FIN;
            end else begin
               state_in = (i_ff + 1'b1 < free_count_ff) ? S_SREAD : S_BUMP;
            end
         end
         S_ERASE_RD: state_in = S_ERASE_WR;
         S_ERASE_WR: state_in = (j_ff + 1'b1 < free_count_ff) ? S_ERASE_RD : S_FIN;
         S_BUMP: begin
            if (!bump_fits || (is_realloc && list_full)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: state_in = is_realloc ? S_APPEND : S_RESP;
         S_APPEND: state_in = S_RESP;
         S_RESP: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      mode_in = mode_ff;
      page_in = page_ff;
      given_in = given_ff;
      i_in = i_ff;
      j_in = j_ff;
      found_in = found_ff;
      fstart_in = fstart_ff;
      flen_in = flen_ff;
      old_in = old_ff;
      free_count_in = free_count_ff;
      bump_in = bump_ff;
      block_count_in = block_count_ff;
      outstanding_in = outstanding_ff;
      set_valid = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      r_status_in = r_status_ff;
      r_start_in = r_start_ff;
      r_len_in = r_len_ff;
      r_cp_in = r_cp_ff;
      r_cfrom_in = r_cfrom_ff;
      r_clen_in = r_clen_ff;
      fl_we = 1'b0;
      fl_waddr = '0;
      fl_wdata = '0;
      fl_raddr = i_ff[PW-1:0];
      blk_we = 1'b0;
      blk_waddr = bidx;
      blk_wdata = need_ff[8:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_mode;
               page_in = req_block_page;
               given_in = req_block_given;
               i_in = '0;
               found_in = 1'b0;
               r_status_in = ST_OK;
               r_start_in = '0;
               r_len_in = '0;
               r_cp_in = 1'b0;
               r_cfrom_in = '0;
               r_clen_in = '0;
            end
         end
         S_NEED: begin
            if (is_realloc || is_free) begin
               if (lk_status != ST_OK) begin
                  r_status_in = lk_status;
               end else if (is_free && list_full) begin
                  r_status_in = ST_LISTFULL;
               end
            end
         end
         S_BREAD: begin
         end
         S_BWAIT: begin
            old_in = blk_rdata;
            if (is_realloc && 25'(blk_rdata) >= need_ff) begin
               r_start_in = page_ff;
               r_len_in = blk_rdata;
            end
         end
         S_SREAD: begin
            fl_raddr = i_ff[PW-1:0];
         end
         S_SCMP: begin
            if (25'(fl_rdata.len) >= need_ff) begin
               found_in = 1'b1;
               fstart_in = fl_rdata.start;
               flen_in = fl_rdata.len;
               j_in = i_ff + 1'b1;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_ERASE_RD: begin
            fl_raddr = j_ff[PW-1:0];
         end
         S_ERASE_WR: begin
            // shift the entry one place down
            fl_we = 1'b1;
            fl_waddr = j_dec[PW-1:0];
            fl_wdata = fl_rdata;
            j_in = j_ff + 1'b1;
         end
         S_BUMP: begin
            if (!bump_fits) begin
               r_status_in = ST_NOPAGES;
            end else if (is_realloc && list_full) begin
               r_status_in = ST_LISTFULL;
            end else begin
               blk_we = 1'b1;
               set_valid = 1'b1;
               if (!valid_ff[bidx]) block_count_in = block_count_ff + 1'b1;
               bump_in = CW'(bump_sum);
               fstart_in = bump_ff[7:0];
               flen_in = need_ff[8:0];
            end
         end
         S_FIN: begin
            if (found_ff) free_count_in = free_count_ff - 1'b1;
            r_start_in = fstart_ff;
            r_len_in = flen_ff;
            if (is_realloc) begin
               r_cp_in = 1'b1;
               r_cfrom_in = page_ff;
               r_clen_in = old_ff;
            end else begin
               outstanding_in = outstanding_ff + 16'd1;
            end
         end
         S_APPEND: begin
            fl_we = 1'b1;
            fl_waddr = free_count_ff[PW-1:0];
            fl_wdata.start = page_ff;
            fl_wdata.len = old_ff;
            free_count_in = free_count_ff + 1'b1;
            if (is_free) begin
               outstanding_in = outstanding_ff - 16'd1;
               r_start_in = page_ff;
            end
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         psl_ff <= PAGE_SIZE_LOG2_RESET;
         pool_ff <= POOL_PAGES_RESET;
         free_count_ff <= '0;
         bump_ff <= '0;
         block_count_ff <= '0;
         outstanding_ff <= '0;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PAGE_SIZE_LOG2: psl_ff <= csr_wdata[4:0];
               CSR_POOL_PAGES:     pool_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         free_count_ff <= free_count_in;
         bump_ff <= bump_in;
         block_count_ff <= block_count_in;
         outstanding_ff <= outstanding_in;
         if (set_valid) valid_ff[bidx] <= 1'b1;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff <= mode_in;
      page_ff <= page_in;
      given_ff <= given_in;
      i_ff <= i_in;
      j_ff <= j_in;
      found_ff <= found_in;
      fstart_ff <= fstart_in;
      flen_ff <= flen_in;
      old_ff <= old_in;
      r_status_ff <= r_status_in;
      r_start_ff <= r_start_in;
      r_len_ff <= r_len_in;
      r_cp_ff <= r_cp_in;
      r_cfrom_ff <= r_cfrom_in;
      r_clen_ff <= r_clen_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = r_status_ff;
   assign rsp_start_page = r_start_ff;
   assign rsp_granted_pages = r_len_ff;
   assign rsp_copy_needed = r_cp_ff;
   assign rsp_copy_from_page = r_cfrom_ff;
   assign rsp_copy_pages = r_clen_ff;
   assign rsp_open_blocks = signed'(outstanding_ff);

   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= MAXC)
      else $error("free list count beyond depth");

   a_bump_bound: assert property (@(posedge clock) disable iff (reset)
      32'(bump_ff) <= TABLE_DEPTH)
      else $error("bump pointer beyond pool");

   a_erase_in_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE_WR) |-> (j_ff < free_count_ff) && found_ff)
      else $error("erase shift outside the free list");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> $stable(free_count_ff) && $stable(outstanding_ff))
      else $error("state changed while idle");

endmodule
